[rtl/core/bet_pkg.sv]
`default_nettype none

package bet_pkg;

   // Token kinds
   localparam logic [3:0] KIND_CONST   = 4'd0;
   localparam logic [3:0] KIND_NOT     = 4'd1;
   localparam logic [3:0] KIND_AND     = 4'd2;
   localparam logic [3:0] KIND_OR      = 4'd3;
   localparam logic [3:0] KIND_LPAREN  = 4'd4;
   localparam logic [3:0] KIND_RPAREN  = 4'd5;
   localparam logic [3:0] KIND_IMPLIES = 4'd6;
   localparam logic [3:0] KIND_ASSIGN  = 4'd7;
   localparam logic [3:0] KIND_EQUIV   = 4'd8;
   localparam logic [3:0] KIND_IDENT   = 4'd9;
   localparam logic [3:0] KIND_END     = 4'd10;
   localparam logic [3:0] KIND_ERROR   = 4'd11;

   // Longest identifier; the name buffer holds at most eight bytes
   localparam int MAX_NAME_CHARS = 8;

   // Result queue depth (power of two, at least two)
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [3:0]  kind;
      logic        const_bit;
      logic [63:0] name_chars;
      logic [3:0]  name_length;
      logic        last;
   } token_type;

   // Tokens produced by one character
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } step_type;

   function automatic token_type make_token(input logic [3:0] kind, input logic bitv,
                                            input logic [63:0] chars,
                                            input logic [3:0] len);
      token_type t;
      t.kind        = kind;
      t.const_bit   = bitv;
      t.name_chars  = chars;
      t.name_length = len;
      t.last        = 1'b0;
      return t;
   endfunction

endpackage

`default_nettype wire

[rtl/core/bet_scan.sv]
`default_nettype none

module bet_scan
   import bet_pkg::*;
#(
   parameter int MAX_NAME_LEN = MAX_NAME_CHARS
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       go,
   input  wire logic [7:0] char_byte,
   output step_type        step
);

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_EQ   = 3'd1;
   localparam logic [2:0] MODE_LT   = 3'd2;
   localparam logic [2:0] MODE_LTEQ = 3'd3;
   localparam logic [2:0] MODE_NAME = 3'd4;
   localparam logic [2:0] MODE_SKIP = 3'd5;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_Z    = 8'h7A;

   localparam logic [3:0] NAME_MAX = 4'(MAX_NAME_LEN);

   typedef struct packed {
      logic       emit;
      logic [3:0] kind;
      logic       bitv;
      logic [2:0] mode;
      logic       start_name;
   } idle_res_type;

   logic [2:0]  mode_ff, mode_in;
   logic [63:0] name_buf_ff, name_buf_in;
   logic [3:0]  name_cnt_ff, name_cnt_in;
   logic        is_letter;
   idle_res_type idle_res;
   token_type   tok0, tok1;
   logic [1:0]  tok_n;

   // Handle one character from the idle mode
   function automatic idle_res_type idle_step(input logic [7:0] c, input logic letter);
      idle_res_type r;
      r.emit       = 1'b0;
      r.kind       = KIND_ERROR;
      r.bitv       = 1'b0;
      r.mode       = MODE_IDLE;
      r.start_name = 1'b0;
      case (c)
         CH_SPACE, CH_TAB: r.emit = 1'b0;
         CH_ZERO:   begin r.emit = 1'b1; r.kind = KIND_CONST; end
         CH_ONE:    begin r.emit = 1'b1; r.kind = KIND_CONST; r.bitv = 1'b1; end
         CH_BANG:   begin r.emit = 1'b1; r.kind = KIND_NOT; end
         CH_AMP:    begin r.emit = 1'b1; r.kind = KIND_AND; end
         CH_BAR:    begin r.emit = 1'b1; r.kind = KIND_OR; end
         CH_LPAREN: begin r.emit = 1'b1; r.kind = KIND_LPAREN; end
         CH_RPAREN: begin r.emit = 1'b1; r.kind = KIND_RPAREN; end
         CH_EQUAL:  r.mode = MODE_EQ;
         CH_LESS:   r.mode = MODE_LT;
         CH_NEWLINE: begin r.emit = 1'b1; r.kind = KIND_END; end
         default: begin
            if (letter) begin
               r.mode       = MODE_NAME;
               r.start_name = 1'b1;
            end else begin
               r.emit = 1'b1;
               r.kind = KIND_ERROR;
               r.mode = MODE_SKIP;
            end
         end
      endcase
      return r;
   endfunction

   assign is_letter = (char_byte inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]});
   assign idle_res  = idle_step(char_byte, is_letter);

   // Decode one character against the current mode
   always_comb begin
      mode_in     = mode_ff;
      name_buf_in = name_buf_ff;
      name_cnt_in = name_cnt_ff;
      tok0        = make_token(KIND_ERROR, 1'b0, '0, '0);
      tok1        = make_token(KIND_ERROR, 1'b0, '0, '0);
      tok_n       = 2'd0;
      case (mode_ff)
         MODE_EQ: begin
            if (char_byte == CH_GREATER) begin
               mode_in = MODE_IDLE;
               tok0    = make_token(KIND_IMPLIES, 1'b0, '0, '0);
               tok_n   = 2'd1;
            end else begin
               tok0    = make_token(KIND_ASSIGN, 1'b0, '0, '0);
               tok1    = make_token(idle_res.kind, idle_res.bitv, '0, '0);
               tok_n   = idle_res.emit ? 2'd2 : 2'd1;
               mode_in = idle_res.mode;
               if (idle_res.start_name) begin
                  name_buf_in = {56'd0, char_byte};
                  name_cnt_in = 4'd1;
               end
            end
         end
         MODE_LT, MODE_LTEQ: begin
            if (mode_ff == MODE_LT && char_byte == CH_EQUAL) begin
               mode_in = MODE_LTEQ;
            end else if (mode_ff == MODE_LTEQ && char_byte == CH_GREATER) begin
               mode_in = MODE_IDLE;
               tok0    = make_token(KIND_EQUIV, 1'b0, '0, '0);
               tok_n   = 2'd1;
            end else begin
               // broken "<=>": error, then end of line if that is what broke it
               tok0 = make_token(KIND_ERROR, 1'b0, '0, '0);
               if (char_byte == CH_NEWLINE) begin
                  tok1    = make_token(KIND_END, 1'b0, '0, '0);
                  tok_n   = 2'd2;
                  mode_in = MODE_IDLE;
               end else begin
                  tok_n   = 2'd1;
                  mode_in = MODE_SKIP;
               end
            end
         end
         MODE_NAME: begin
            if (is_letter) begin
               if (name_cnt_ff < NAME_MAX) begin
                  name_buf_in[{name_cnt_ff[2:0], 3'b000} +: 8] = char_byte;
                  name_cnt_in = name_cnt_ff + 4'd1;
               end else begin
                  name_buf_in = '0;
                  name_cnt_in = '0;
                  mode_in     = MODE_SKIP;
                  tok0        = make_token(KIND_ERROR, 1'b0, '0, '0);
                  tok_n       = 2'd1;
               end
            end else begin
               // close the name, then treat the character as in idle
               tok0        = make_token(KIND_IDENT, 1'b0, name_buf_ff, name_cnt_ff);
               tok1        = make_token(idle_res.kind, idle_res.bitv, '0, '0);
               tok_n       = idle_res.emit ? 2'd2 : 2'd1;
               mode_in     = idle_res.mode;
               name_buf_in = '0;
               name_cnt_in = '0;
            end
         end
         MODE_SKIP: begin
            if (char_byte == CH_NEWLINE) begin
               tok0    = make_token(KIND_END, 1'b0, '0, '0);
               tok_n   = 2'd1;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            tok0    = make_token(idle_res.kind, idle_res.bitv, '0, '0);
            tok_n   = idle_res.emit ? 2'd1 : 2'd0;
            mode_in = idle_res.mode;
            if (idle_res.start_name) begin
               name_buf_in = {56'd0, char_byte};
               name_cnt_in = 4'd1;
            end else begin
               name_buf_in = '0;
               name_cnt_in = '0;
            end
         end
      endcase
   end

   // Mark the final token of this beat
   always_comb begin
      step.count     = tok_n;
      step.tok0      = tok0;
      step.tok1      = tok1;
      step.tok0.last = (tok_n == 2'd1);
      step.tok1.last = 1'b1;
   end

   // Advance state on each processed character
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         name_buf_ff <= '0;
         name_cnt_ff <= '0;
      end else if (go) begin
         mode_ff     <= mode_in;
         name_buf_ff <= name_buf_in;
         name_cnt_ff <= name_cnt_in;
      end
   end

   a_name_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_NAME) |-> (name_cnt_ff == 4'd0 && name_buf_ff == 64'd0))
      else $error("name buffer not clear outside a name");

   a_name_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_NAME) |-> (name_cnt_ff != 4'd0 && name_cnt_ff <= NAME_MAX))
      else $error("name count out of range");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff <= MODE_SKIP)
      else $error("unused scan mode reached");

endmodule

`default_nettype wire

[rtl/core/bet_fifo.sv]
`default_nettype none

module bet_fifo
   import bet_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire step_type step,
   output logic          room,
   output logic          out_valid,
   input  wire logic     out_ready,
   output token_type     out_tok
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   token_type             mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      push_n;
   logic                  pop;
   logic [PTR_W-1:0]      wr_next;

   assign push_n    = push ? CNT_W'(step.count) : '0;
   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_tok   = mem_ff[rd_ptr_ff];
   assign room      = (cnt_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + push_n - (pop ? CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store up to two tokens per beat
   always_ff @(posedge clock) begin
      if (push && step.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= step.tok0;
      end
      if (push && step.count == 2'd2) begin
         mem_ff[wr_next] <= step.tok1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (CNT_W'(cnt_ff) + push_n <= CNT_W'(FIFO_DEPTH)))
      else $error("result queue overflow");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !push && !pop && out_valid |=> out_valid)
      else $error("queue lost an entry");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("push without room");

endmodule

`default_nettype wire

[rtl/core/boolean_expression_tokenizer_unit.sv]
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_char_byte[7:0]
// rsp_      out        rsp_valid/rsp_ready   rsp_token_kind[3:0], rsp_const_bit,
//                                            rsp_name_chars[63:0], rsp_name_length[3:0],
//                                            rsp_last
//
// One character per cycle while the queue has room: a beat lands in the input
// register, is decoded against the scan state combinationally, and its zero to two
// tokens enter a four-entry queue. A token passes through the input register, then
// the queue, before rsp_ offers it.
// A character that makes two tokens offers them in turn on the single output port.
// The input register holds while the queue has fewer than two free entries.
// Reset (synchronous) returns the scanner to idle and empties the queue.

module boolean_expression_tokenizer_unit
   import bet_pkg::*;
#(
   parameter int MAX_NAME_LEN = MAX_NAME_CHARS
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_token_kind,
   output logic             rsp_const_bit,
   output logic [63:0]      rsp_name_chars,
   output logic [3:0]       rsp_name_length,
   output logic             rsp_last
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff;
   logic       go;
   logic       room;
   logic       req_fire;
   step_type   step;
   token_type  head;

   assign go        = in_vld_ff && room;
   assign req_ready = !in_vld_ff || go;
   assign req_fire  = req_valid && req_ready;
   assign in_vld_in = req_fire ? 1'b1 : (go ? 1'b0 : in_vld_ff);

   // Hold the input beat until the scanner takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_char_byte;
      end
   end

   bet_scan #(
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .char_byte (in_char_ff),
      .step      (step)
   );

   bet_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (go),
      .step      (step),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_tok   (head)
   );

   assign rsp_token_kind  = head.kind;
   assign rsp_const_bit   = head.const_bit;
   assign rsp_name_chars  = head.name_chars;
   assign rsp_name_length = head.name_length;
   assign rsp_last        = head.last;

endmodule

`default_nettype wire
